>>> hdl/bpa_pkg.sv
// bpa_pkg: shared constants, types and bit helpers of the bitmap page allocator
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

    localparam int NUM_PAGES = 65536;
    localparam int PAGE_W    = 16;                  // page index width
    localparam int CNT_W     = 17;                  // count, cursor and limit width
    localparam int WORD_W    = 32;                  // map bits per memory word
    localparam int BIT_W     = 5;                   // bit index within a word
    localparam int NUM_WORDS = NUM_PAGES / WORD_W;
    localparam int WADDR_W   = PAGE_W - BIT_W;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] PAGES_ALL = CNT_W'(NUM_PAGES);

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_MARK  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_DFREE = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SRD,
        S_SCAN,
        S_MRD,
        S_MWR,
        S_OUT
    } t_state;

    // bits below position n set, n from 0 to 32
    function automatic logic [WORD_W-1:0] low_mask(input logic [BIT_W:0] n);
        logic [WORD_W-1:0] m;
        for (int i = 0; i < WORD_W; i++) begin
            m[i] = (BIT_W+1)'(i) < n;
        end
        return m;
    endfunction

    // index of the lowest set bit, 32 when none
    function automatic logic [BIT_W:0] lowest_one(input logic [WORD_W-1:0] w);
        logic [BIT_W:0] idx;
        idx = (BIT_W+1)'(WORD_W);
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = (BIT_W+1)'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> hdl/bitmap_page_allocator_unit.sv
// bitmap_page_allocator_unit: next-fit page allocator over a word-wide used map
// allocate: a read and a scan per map word entered, a scan per used page passed short of
//   a word end, a read per search pass that runs to its bound, a read and a write per word marked
// free and mark-free: a read and a write per map word touched; a range error touches none
// the used-map memory (one read, one write port) sets the pace, one item at a time
// after reset a fill pass over all 2048 map words sets every page used; no item is taken then
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: page_limit
    input  wire logic        i_cfg_wr_en,
    input  wire logic [16:0] i_cfg_wr_data,
    // request stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,  // start_page[15:0], page_count[32:16], zeros
    input  wire logic [1:0]  i_s_axis_tuser,  // operation[1:0]
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [39:0] o_m_axis_tdata   // found_page[15:0], status[17:16],
                                              // pages_in_use[34:18], zeros
);

    import bpa_pkg::*;

    t_state r_state, n_state;

    logic [CNT_W-1:0]   r_page_limit;
    logic [CNT_W-1:0]   r_cur, n_cur;
    logic [CNT_W-1:0]   r_run, n_run;
    logic [CNT_W-1:0]   r_bound, n_bound;
    logic [CNT_W-1:0]   r_old, n_old;
    logic [CNT_W-1:0]   r_lim, n_lim;
    logic               r_pass2, n_pass2;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [1:0]         r_op, n_op;
    logic [CNT_W-1:0]   r_pos, n_pos;
    logic [CNT_W-1:0]   r_end, n_end;
    logic [CNT_W-1:0]   r_cleared, n_cleared;
    logic [1:0]         r_status, n_status;
    logic [PAGE_W-1:0]  r_found, n_found;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [WADDR_W-1:0] r_ini;
    logic               r_ov;
    logic [39:0]        r_odata;

    logic               s_accept, out_load;
    logic [1:0]         in_op;
    logic [PAGE_W-1:0]  in_start;
    logic [CNT_W-1:0]   in_n;
    logic [CNT_W-1:0]   lim;
    logic [CNT_W:0]     range_end;

    logic               ram_we;
    logic [WADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, rd_data;

    // scan signals
    logic [CNT_W-1:0]   base_cur, cur_room, hit_start, adv_cur, skip_cur;
    logic [BIT_W:0]     nxt_used, scan_end, scan_stop, scan_k;
    logic [CNT_W:0]     run_sum;
    logic               hit, blocked, stay_word, pass_done;

    // mark/clear signals
    logic [CNT_W-1:0]   base_pos, pos_room, next_pos;
    logic [BIT_W:0]     m_end, free_hit, clear_n;
    logic [WORD_W-1:0]  rng_mask, free_mask;
    logic               dbl, walk_done;
    logic [CNT_W:0]     cnt_sum;

    bpa_ram #(
        .DEPTH (NUM_WORDS),
        .WIDTH (WORD_W)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (rd_data)
    );

    assign in_op    = i_s_axis_tuser;
    assign in_start = i_s_axis_tdata[15:0];
    assign in_n     = i_s_axis_tdata[32:16];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load        = (r_state == S_OUT) && (!r_ov || i_m_axis_tready);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;

    assign lim       = (r_page_limit > PAGES_ALL) ? PAGES_ALL : r_page_limit;
    assign range_end = {2'b00, in_start} + {1'b0, in_n};

    // allocation scan over the word holding the cursor
    assign base_cur  = {r_cur[CNT_W-1:BIT_W], {BIT_W{1'b0}}};
    assign cur_room  = r_bound - base_cur;
    assign scan_end  = (cur_room >= CNT_W'(WORD_W)) ? (BIT_W+1)'(WORD_W)
                                                    : cur_room[BIT_W:0];
    assign nxt_used  = lowest_one(rd_data & ~low_mask({1'b0, r_cur[BIT_W-1:0]}));
    assign blocked   = nxt_used < scan_end;
    assign scan_stop = blocked ? nxt_used : scan_end;
    assign scan_k    = scan_stop - {1'b0, r_cur[BIT_W-1:0]};
    assign run_sum   = {1'b0, r_run} + {{(CNT_W-BIT_W){1'b0}}, scan_k};
    assign hit       = run_sum >= {1'b0, r_n};
    assign hit_start = r_cur - r_run;
    assign adv_cur   = base_cur + {{(CNT_W-BIT_W-1){1'b0}}, nxt_used} + CNT_W'(1);
    assign skip_cur  = base_cur + {{(CNT_W-BIT_W-1){1'b0}}, scan_stop};
    // after a used page the next position can be checked without a new read
    assign stay_word = (adv_cur[BIT_W-1:0] != '0) && (adv_cur < r_bound);
    assign pass_done = r_cur >= r_bound;

    // range walk for marking and clearing
    assign base_pos  = {r_pos[CNT_W-1:BIT_W], {BIT_W{1'b0}}};
    assign pos_room  = r_end - base_pos;
    assign m_end     = (pos_room >= CNT_W'(WORD_W)) ? (BIT_W+1)'(WORD_W)
                                                    : pos_room[BIT_W:0];
    assign rng_mask  = low_mask(m_end) & ~low_mask({1'b0, r_pos[BIT_W-1:0]});
    assign free_hit  = lowest_one(~rd_data & rng_mask);
    assign dbl       = (r_op == OP_FREE) && !free_hit[BIT_W];
    assign free_mask = dbl ? (rng_mask & low_mask(free_hit)) : rng_mask;
    assign clear_n   = (dbl ? free_hit : m_end) - {1'b0, r_pos[BIT_W-1:0]};
    assign next_pos  = base_pos + {{(CNT_W-BIT_W-1){1'b0}}, m_end};
    assign walk_done = dbl || (next_pos >= r_end);

    assign cnt_sum   = {1'b0, r_count} + {1'b0, r_n};

    // memory ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos[PAGE_W-1:BIT_W];
        ram_wdata = rd_data & ~rng_mask;
        ram_raddr = r_cur[PAGE_W-1:BIT_W];
        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_ini;
                ram_wdata = {WORD_W{1'b1}};
            end
            S_MRD: begin
                ram_raddr = r_pos[PAGE_W-1:BIT_W];
            end
            S_MWR: begin
                ram_we    = 1'b1;
                ram_raddr = r_pos[PAGE_W-1:BIT_W];
                case (r_op)
                    OP_ALLOC: ram_wdata = rd_data | rng_mask;
                    OP_FREE:  ram_wdata = rd_data & ~free_mask;
                    default:  ram_wdata = rd_data & ~rng_mask;
                endcase
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_ini == WADDR_W'(NUM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_OUT;
                    if (in_op == OP_ALLOC) begin
                        if (in_n != '0) begin
                            n_state = S_SRD;
                        end
                    end else if (in_op == OP_FREE || in_op == OP_MARK) begin
                        if (range_end <= {1'b0, lim} && in_n != '0) begin
                            n_state = S_MRD;
                        end
                    end
                end
            end
            S_SRD: begin
                if (pass_done) begin
                    if (r_pass2) begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = S_MRD;
                end else if (blocked && stay_word) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_MRD: begin
                n_state = S_MWR;
            end
            S_MWR: begin
                n_state = walk_done ? S_OUT : S_MRD;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_cur     = r_cur;
        n_run     = r_run;
        n_bound   = r_bound;
        n_old     = r_old;
        n_lim     = r_lim;
        n_pass2   = r_pass2;
        n_n       = r_n;
        n_op      = r_op;
        n_pos     = r_pos;
        n_end     = r_end;
        n_cleared = r_cleared;
        n_status  = r_status;
        n_found   = r_found;
        n_count   = r_count;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_op      = in_op;
                    n_n       = in_n;
                    n_found   = '0;
                    n_status  = ST_OK;
                    n_cleared = '0;
                    n_run     = '0;
                    n_pass2   = 1'b0;
                    n_old     = r_cur;
                    n_lim     = lim;
                    n_bound   = lim;
                    n_pos     = {1'b0, in_start};
                    n_end     = range_end[CNT_W-1:0];
                    if (in_op == OP_ALLOC) begin
                        if (in_n == '0) begin
                            // a zero-page request is answered as out of memory, without a search
                            n_status = ST_OOM;
                            n_cur    = (r_cur < lim) ? r_cur : lim;
                        end
                    end else if (in_op == OP_FREE || in_op == OP_MARK) begin
                        if (range_end > {1'b0, lim}) begin
                            n_status = ST_RANGE;
                        end
                    end
                end
            end
            S_SRD: begin
                if (pass_done) begin
                    if (r_pass2) begin
                        n_status = ST_OOM;
                        n_found  = '0;
                    end else begin
                        // wrap: second pass from page zero up to the old cursor, capped at the limit
                        n_pass2 = 1'b1;
                        n_cur   = '0;
                        n_run   = '0;
                        n_bound = (r_old < r_lim) ? r_old : r_lim;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_cur   = hit_start + r_n;
                    n_found = hit_start[PAGE_W-1:0];
                    n_pos   = hit_start;
                    n_end   = hit_start + r_n;
                end else if (blocked) begin
                    n_run = '0;
                    n_cur = adv_cur;
                end else begin
                    n_run = run_sum[CNT_W-1:0];
                    n_cur = skip_cur;
                end
            end
            S_MWR: begin
                n_pos     = next_pos;
                n_cleared = r_cleared + {{(CNT_W-BIT_W-1){1'b0}}, clear_n};
                if (dbl) begin
                    n_status = ST_DFREE;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    if (r_op == OP_ALLOC && r_status == ST_OK) begin
                        n_count = cnt_sum[CNT_W] ? COUNT_MAX : cnt_sum[CNT_W-1:0];
                    end else if (r_op == OP_FREE && r_status != ST_RANGE) begin
                        n_count = (r_cleared > r_count) ? '0 : r_count - r_cleared;
                    end
                end
            end
            default: begin
                n_cur = r_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_ini        <= '0;
            r_page_limit <= PAGES_ALL;
            r_cur        <= '0;
            r_count      <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_count <= n_count;
            if (r_state == S_INIT) begin
                r_ini <= r_ini + WADDR_W'(1);
            end
            if (i_cfg_wr_en) begin
                r_page_limit <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_run     <= n_run;
        r_bound   <= n_bound;
        r_old     <= n_old;
        r_lim     <= n_lim;
        r_pass2   <= n_pass2;
        r_n       <= n_n;
        r_op      <= n_op;
        r_pos     <= n_pos;
        r_end     <= n_end;
        r_cleared <= n_cleared;
        r_status  <= n_status;
        r_found   <= n_found;
        if (out_load) begin
            r_odata <= {5'b00000, n_count, r_status, r_found};
        end
    end

endmodule

`default_nettype wire

>>> hdl/bpa_ram.sv
// bpa_ram: simple dual-port synchronous ram, registered read data
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire
